// ===== rtl/core/fdsu_pkg.sv =====
// Package for the Forth stack unit: word codes, status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package fdsu_pkg;

  typedef enum logic [4:0] {
    F_LIT = 5'd0, F_DUP = 5'd1, F_2DUP = 5'd2, F_DROP = 5'd3, F_CLEAR = 5'd4,
    F_SWAP = 5'd5, F_2SWAP = 5'd6, F_OVER = 5'd7, F_2OVER = 5'd8, F_OVER2 = 5'd9,
    F_ROT = 5'd10, F_NROT = 5'd11, F_A2D = 5'd12, F_D2A = 5'd13, F_ACOPY = 5'd14,
    F_PICK = 5'd15, F_ROLL = 5'd16
  } func_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_INDEX = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_WR, S_IDX, S_MOVE, S_MOVEW, S_TOP, S_TOPW, S_DONE
  } state_e;

  // per-code requirements: data need, data growth, aux need, aux growth
  typedef struct packed {
    logic [2:0] dneed;
    logic [1:0] dgrow;
    logic       aneed;
    logic       agrow;
  } req_t;

  function automatic req_t func_req(input logic [4:0] f);
    req_t r;
    r = '0;
    case (f)
      F_LIT:   r.dgrow = 2'd1;
      F_DUP:   begin r.dneed = 3'd1; r.dgrow = 2'd1; end
      F_2DUP:  begin r.dneed = 3'd2; r.dgrow = 2'd2; end
      F_DROP:  r.dneed = 3'd1;
      F_SWAP:  r.dneed = 3'd2;
      F_2SWAP: r.dneed = 3'd4;
      F_OVER:  begin r.dneed = 3'd2; r.dgrow = 2'd1; end
      F_2OVER: begin r.dneed = 3'd4; r.dgrow = 2'd2; end
      F_OVER2: begin r.dneed = 3'd3; r.dgrow = 2'd1; end
      F_ROT:   r.dneed = 3'd3;
      F_NROT:  r.dneed = 3'd3;
      F_A2D:   begin r.aneed = 1'b1; r.dgrow = 2'd1; end
      F_D2A:   begin r.dneed = 3'd1; r.agrow = 1'b1; end
      F_ACOPY: begin r.aneed = 1'b1; r.dgrow = 2'd1; end
      F_PICK:  r.dneed = 3'd1;
      F_ROLL:  r.dneed = 3'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/forth_dual_stack_unit.sv =====
// Forth data/aux stack unit: top level with sequencer, two stack RAMs.
// Depends on fdsu_pkg and fdsu_ram.
//
// Channel | Direction | Handshake        | Fields
// request | in        | start / busy     | func_i, literal_i
// result  | out       | done_o (strobe)  | status_o, top_value_o, data_count_o,
//         |           |                  | aux_top_o, aux_count_o, error_seen_o
//
// Fixed words read their entries from the RAM one at a time (plus the aux top where needed),
// then write their entries back one at a time. Unused codes, underflow and overflow
// skip straight to the top refresh. Pick/roll read the index, then walk the entries.
// busy drops the cycle after done_o.
// Reset clears counts and the flag; RAM contents need no clearing. Results cannot be stalled.
`timescale 1ns / 1ps
module forth_dual_stack_unit #(
  parameter int DATA_DEPTH = 64,
  parameter int AUX_DEPTH  = 64,
  parameter int WORD_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  func_i,
  input  logic signed [15:0] literal_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic signed [15:0] top_value_o,
  output logic [6:0]  data_count_o,
  output logic signed [15:0] aux_top_o,
  output logic [6:0]  aux_count_o,
  output logic        error_seen_o
);
  import fdsu_pkg::*;

  localparam int DA = $clog2(DATA_DEPTH);
  localparam int AA = $clog2(AUX_DEPTH);
  localparam int DC = $clog2(DATA_DEPTH + 1);
  localparam int AC = $clog2(AUX_DEPTH + 1);
  localparam int W  = WORD_BITS;

  state_e state_q, state_d;
  logic [4:0]   func_q, func_d;
  logic [W-1:0] lit_q, lit_d;
  logic [DC-1:0] dn_q, dn_d;
  logic [AC-1:0] an_q, an_d;
  logic          err_q, err_d;
  logic [1:0]    stat_q, stat_d;
  logic [2:0]    cnt_q, cnt_d;      // fixed-word read/write step
  logic [W-1:0]  buf_q [4];
  logic [W-1:0]  buf_d [4];
  logic [W-1:0]  abuf_q, abuf_d;
  logic [DC-1:0] ptr_q, ptr_d;      // pick/roll walking index
  logic [DC-1:0] end_q, end_d;
  logic [W-1:0]  held_q, held_d;    // moved element

  logic          dwe, awe;
  logic [DA-1:0] dwa, dra;
  logic [AA-1:0] awa, ara;
  logic [W-1:0]  dwd, awd, drd, ard;

  fdsu_ram #(.Width(W), .Depth(DATA_DEPTH)) u_dram (
    .clk_i, .we_i(dwe), .waddr_i(dwa), .wdata_i(dwd), .raddr_i(dra), .rdata_o(drd));
  fdsu_ram #(.Width(W), .Depth(AUX_DEPTH)) u_aram (
    .clk_i, .we_i(awe), .waddr_i(awa), .wdata_i(awd), .raddr_i(ara), .rdata_o(ard));

  req_t req;
  logic [DC+1:0] dgrown;
  logic [AC:0]   agrown;
  logic [2:0]    nrd, nwr;
  logic [W-1:0]  wsrc;
  logic [DC-1:0] wofs;

  always_comb begin
    req    = func_req(func_q);
    dgrown = DC'(0) + (DC+2)'(dn_q) + (DC+2)'(req.dgrow);
    agrown = (AC+1)'(an_q) + (AC+1)'(req.agrow);
  end

  // entries read from the top (buf[i] = w[n-nrd+i]) and written back
  always_comb begin
    nrd = req.dneed;
    nwr = 3'd0;
    case (func_q)
      F_LIT, F_DUP, F_OVER, F_OVER2, F_A2D, F_ACOPY: nwr = 3'd1;
      F_2DUP, F_2OVER, F_SWAP: nwr = 3'd2;
      F_2SWAP: nwr = 3'd4;
      F_ROT, F_NROT: nwr = 3'd3;
      default: nwr = 3'd0;
    endcase
  end

  // write step cnt: data source and offset from old n (addr = n - nrd + wofs)
  always_comb begin
    wsrc = '0;
    wofs = '0;
    case (func_q)
      F_LIT:   begin wsrc = lit_q;  wofs = DC'(nrd); end
      F_DUP:   begin wsrc = buf_q[0]; wofs = DC'(1); end
      F_2DUP:  begin wsrc = buf_q[cnt_q[1:0]]; wofs = DC'(2) + DC'(cnt_q); end
      F_OVER:  begin wsrc = buf_q[0]; wofs = DC'(2); end
      F_2OVER: begin wsrc = buf_q[cnt_q[1:0]]; wofs = DC'(4) + DC'(cnt_q); end
      F_OVER2: begin wsrc = buf_q[0]; wofs = DC'(3); end
      F_A2D, F_ACOPY: begin wsrc = abuf_q; wofs = '0; end
      F_SWAP:  begin wsrc = buf_q[{1'b0, ~cnt_q[0]}]; wofs = DC'(cnt_q); end
      F_2SWAP: begin wsrc = buf_q[{~cnt_q[1], cnt_q[0]}]; wofs = DC'(cnt_q); end
      F_ROT:   begin
        wsrc = (cnt_q == 3'd2) ? buf_q[0] : buf_q[cnt_q[1:0] + 2'd1];
        wofs = DC'(cnt_q);
      end
      F_NROT:  begin
        wsrc = (cnt_q == 3'd0) ? buf_q[2] : buf_q[cnt_q[1:0] - 2'd1];
        wofs = DC'(cnt_q);
      end
      default: ;
    endcase
  end

  logic [DC-1:0] base;
  logic [W-1:0]  k;
  logic [DC-1:0] m;   // count after popping k
  always_comb base = dn_q - DC'(nrd);

  always_comb begin
    state_d = state_q; func_d = func_q; lit_d = lit_q; dn_d = dn_q; an_d = an_q;
    err_d = err_q; stat_d = stat_q; cnt_d = cnt_q; buf_d = buf_q; abuf_d = abuf_q;
    ptr_d = ptr_q; end_d = end_q; held_d = held_q;
    dwe = 1'b0; awe = 1'b0; dwa = '0; dra = '0; awa = '0; ara = '0;
    dwd = wsrc; awd = buf_q[0];
    done_o = 1'b0;
    k = drd;
    m = dn_q - DC'(1);
    case (state_q)
      S_IDLE: if (start) begin
        func_d = func_i;
        lit_d  = W'(literal_i);
        cnt_d  = '0;
        stat_d = ST_OK;
        state_d = S_RD;
      end
      S_RD: begin
        if (func_q > F_ROLL) begin
          state_d = S_TOP;
        end else if (DC'(req.dneed) > dn_q || AC'(req.aneed) > an_q) begin
          stat_d = ST_UNDER; state_d = S_TOP;
        end else if (dgrown > (DC+2)'(DATA_DEPTH) || agrown > (AC+1)'(AUX_DEPTH)) begin
          stat_d = ST_OVER; state_d = S_TOP;
        end else if (func_q == F_PICK || func_q == F_ROLL) begin
          dra = DA'(dn_q - DC'(1));
          state_d = S_IDX;
        end else if (cnt_q < nrd || (req.aneed && cnt_q == nrd)) begin
          dra = DA'(base + DC'(cnt_q));
          ara = AA'(an_q - AC'(1));
          state_d = S_RDW;
        end else begin
          cnt_d = '0; state_d = S_WR;
        end
      end
      S_RDW: begin
        if (cnt_q < nrd) buf_d[cnt_q[1:0]] = drd;
        else abuf_d = ard;
        cnt_d = cnt_q + 3'd1;
        state_d = S_RD;
      end
      S_WR: begin
        if (cnt_q < nwr) begin
          dwe = 1'b1;
          dwa = DA'(base + wofs);
          cnt_d = cnt_q + 3'd1;
        end else begin
          case (func_q)
            F_D2A: begin
              awe = 1'b1; awa = AA'(an_q);
              an_d = an_q + AC'(1); dn_d = dn_q - DC'(1);
            end
            F_A2D: begin an_d = an_q - AC'(1); dn_d = dgrown[DC-1:0]; end
            F_DROP: dn_d = dn_q - DC'(1);
            F_CLEAR: dn_d = '0;
            default: dn_d = dgrown[DC-1:0];
          endcase
          state_d = S_TOP;
        end
      end
      S_IDX: begin
        dn_d = m;
        if (k[W-1] || (W+DC)'(k) >= (W+DC)'(m)) begin
          err_d = 1'b1; stat_d = ST_INDEX; state_d = S_TOP;
        end else begin
          // j = m-1-k; pick walks j..m-1 upward, roll walks m-1..j downward
          if (func_q == F_PICK) begin
            ptr_d = m - DC'(1) - k[DC-1:0]; end_d = m - DC'(1);
          end else begin
            ptr_d = m - DC'(1); end_d = m - DC'(1) - k[DC-1:0];
          end
          cnt_d = '0;
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        dra = DA'(ptr_q);
        state_d = S_MOVEW;
      end
      S_MOVEW: begin
        // first visit captures the moved element; later ones shift by one
        if (cnt_q == 3'd0) begin
          held_d = drd; cnt_d = 3'd1;
        end else begin
          dwe = 1'b1;
          dwa = (func_q == F_PICK) ? DA'(ptr_q - DC'(1)) : DA'(ptr_q + DC'(1));
          dwd = drd;
        end
        if (ptr_q == end_q) begin
          state_d = S_TOP;
          if (!(cnt_q == 3'd0)) begin end
          // final placement of held element
          held_d = (cnt_q == 3'd0) ? drd : held_q;
          cnt_d = 3'd5;
          state_d = S_TOPW;
          // the held element is always written at end in the TOPW slot
        end else begin
          ptr_d = (func_q == F_PICK) ? ptr_q + DC'(1) : ptr_q - DC'(1);
          state_d = S_MOVE;
        end
      end
      S_TOPW: begin
        // place held element at end index, then refresh tops
        dwe = 1'b1; dwa = DA'(end_q); dwd = held_q;
        state_d = S_TOP;
      end
      S_TOP: begin
        dra = DA'(dn_q - DC'(1));
        ara = AA'(an_q - AC'(1));
        state_d = S_DONE;
      end
      S_DONE: begin
        done_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; dn_q <= '0; an_q <= '0; err_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d; dn_q <= dn_d; an_q <= an_d; err_q <= err_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; lit_q <= lit_d; stat_q <= stat_d; buf_q <= buf_d;
    abuf_q <= abuf_d; ptr_q <= ptr_d; end_q <= end_d; held_q <= held_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign status_o     = stat_q;
  assign top_value_o  = (dn_q == '0) ? 16'sd0 : 16'(drd);
  assign aux_top_o    = (an_q == '0) ? 16'sd0 : 16'(ard);
  assign data_count_o = 7'(dn_q);
  assign aux_count_o  = 7'(an_q);
  assign error_seen_o = err_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dn_q <= DC'(DATA_DEPTH) && an_q <= AC'(AUX_DEPTH))
    else $error("stack count beyond depth");
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q) else $error("sticky error cleared");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside a request");
  a_index_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_INDEX) |-> err_q) else $error("index status without flag");
`endif
endmodule

// ===== rtl/core/fdsu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fdsu_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
